// File: hw/rtl/swm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window minimum block.
// ---------------------------------------------------------------------------
package swm_pkg;

    // Width of the window length register and of the stored sample index.
    localparam int WLEN_W = 9;
    localparam int IDX_W  = 9;

    // Command codes carried on the input channel's tuser.
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_POP   = 4'b0010,
        ST_FRONT = 4'b0100,
        ST_OUT   = 4'b1000
    } swm_state_t;

endpackage : swm_pkg
`default_nettype wire

// File: hw/rtl/swm_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// swm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
module swm_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : swm_ram
`default_nettype wire

// File: hw/rtl/sliding_window_minimum.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sliding_window_minimum
// Minimum over the most recent window_length samples, kept with a
// monotonic deque of (value, index) pairs held in a block RAM.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one command per transaction: tuser selects add
//   (push a new sample) or update (replace the newest sample), tdata holds
//   the sample. Every accepted transaction produces exactly one transaction
//   on the m_ channel: tdata is the window minimum, tuser flags an update
//   that arrived before any sample was added.
//   cfg_wr_en / cfg_wr_data set the window length; write it only while the
//   block is idle. Zero acts as one, values above MAX_WINDOW saturate.
// Command flow:
//   An add with a window of one, the very first add, an early update and an
//   update on an empty deque finish in the accept cycle (one item per cycle
//   while the output register is free). Other updates read the front entry
//   in ST_FRONT; other adds pop from the back in ST_POP, commit the previous
//   sample, then expire from the front in ST_FRONT, one deque RAM read per
//   step. s_tready is high only in ST_IDLE, between commands.
// Reset and stalls:
//   Reset empties the deque, sets the window length to one and the minimum
//   to zero. The result sits in an output register; while it waits the block
//   still takes and finishes one more item, then holds it until m_tready.
// ---------------------------------------------------------------------------
module sliding_window_minimum
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW   = 256,
    parameter int SAMPLE_WIDTH = 32,
    localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Configuration.
    input  wire logic               cfg_wr_en,
    input  wire logic [WLEN_W-1:0]  cfg_wr_data,   // window_length
    // Input stream.
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,       // sample_value, zero padded
    input  wire logic               s_tuser,       // cmd
    // Result stream.
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,       // window_min, zero padded
    output logic                    m_tuser        // error
);

    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int ENT_W   = IDX_W + SAMPLE_WIDTH;
    localparam int WIN_CAP = (MAX_WINDOW < 511) ? MAX_WINDOW : 511;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(MAX_WINDOW - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(MAX_WINDOW - 1) : p - PTR_W'(1);
    endfunction

    // Control state.
    swm_state_t               state_reg,  state_next;
    logic [PTR_W-1:0]         head_reg,   head_next;
    logic [PTR_W-1:0]         tail_reg,   tail_next;
    logic [CNT_W-1:0]         count_reg,  count_next;
    logic [IDX_W-1:0]         sidx_reg,   sidx_next;
    logic                     has_reg,    has_next;
    logic [WLEN_W-1:0]        wlen_reg;
    logic signed [SAMPLE_WIDTH-1:0] cur_reg,  cur_next;
    logic signed [SAMPLE_WIDTH-1:0] min_reg,  min_next;
    logic                     err_reg,    err_next;
    logic                     is_add_reg, is_add_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg, sample_next;

    // Output register.
    logic                     m_valid_reg, m_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] m_data_reg, m_data_next;
    logic                     m_err_reg,   m_err_next;

    // RAM access and read-during-write bypass.
    logic                     wr_en, rd_en;
    logic [PTR_W-1:0]         wr_addr, rd_addr;
    logic [ENT_W-1:0]         wr_data, ram_q, q;
    logic                     fwd_reg, fwd_next;
    logic [ENT_W-1:0]         fwd_data_reg;

    logic signed [SAMPLE_WIDTH-1:0] v_in, q_val, front_min;
    logic [IDX_W-1:0]         q_idx, idx_age;
    logic [WLEN_W-1:0]        w_eff;
    logic                     w_one, expire, back_pop, full, out_free, finish;
    logic [PTR_W-1:0]         tail_prev, tail_prev2, head_nxt, head_push;

    swm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    assign q      = fwd_reg ? fwd_data_reg : ram_q;
    assign q_val  = $signed(q[SAMPLE_WIDTH-1:0]);
    assign q_idx  = q[ENT_W-1:SAMPLE_WIDTH];
    assign v_in   = $signed(s_tdata[SAMPLE_WIDTH-1:0]);

    assign w_eff  = (wlen_reg == '0) ? WLEN_W'(1)
                  : ((wlen_reg > WLEN_W'(WIN_CAP)) ? WLEN_W'(WIN_CAP) : wlen_reg);
    assign w_one  = (w_eff == WLEN_W'(1));

    assign tail_prev  = ring_prev(tail_reg);
    assign tail_prev2 = ring_prev(tail_prev);
    assign head_nxt   = ring_next(head_reg);
    assign full       = (count_reg == CNT_W'(MAX_WINDOW));
    assign head_push  = full ? head_nxt : head_reg;

    // The back entry is popped while it is not smaller than the value committed.
    assign back_pop  = (count_reg != '0) && !(q_val < cur_reg);
    assign idx_age   = sidx_reg - q_idx;
    assign expire    = ({1'b0, idx_age} + (IDX_W + 1)'(1)) >= {1'b0, w_eff};
    assign front_min = (q_val < sample_reg) ? q_val : sample_reg;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        sidx_next   = sidx_reg;
        has_next    = has_reg;
        cur_next    = cur_reg;
        min_next    = min_reg;
        err_next    = err_reg;
        is_add_next = is_add_reg;
        sample_next = sample_reg;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_reg;
        wr_data     = {sidx_reg, cur_reg};
        finish      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sample_next = v_in;
                    if (s_tuser == CMD_ADD) begin
                        is_add_next = 1'b1;
                        if (!has_reg || w_one) begin
                            cur_next  = v_in;
                            min_next  = v_in;
                            err_next  = 1'b0;
                            sidx_next = sidx_reg + IDX_W'(1);
                            has_next  = 1'b1;
                            finish    = 1'b1;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = tail_prev;
                            state_next = ST_POP;
                        end
                    end else begin
                        is_add_next = 1'b0;
                        if (!has_reg) begin
                            // Early update: state stays, the last minimum repeats.
                            err_next = 1'b1;
                            finish   = 1'b1;
                        end else if (count_reg == '0) begin
                            cur_next = v_in;
                            min_next = v_in;
                            err_next = 1'b0;
                            finish   = 1'b1;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = ST_FRONT;
                        end
                    end
                end
            end
            ST_POP: begin
                if (back_pop) begin
                    tail_next  = tail_prev;
                    count_next = count_reg - CNT_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = tail_prev2;
                end else begin
                    // Commit the current value at the back; a full ring loses its front.
                    wr_en      = 1'b1;
                    tail_next  = ring_next(tail_reg);
                    head_next  = head_push;
                    count_next = full ? count_reg : count_reg + CNT_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = head_push;
                    state_next = ST_FRONT;
                end
            end
            ST_FRONT: begin
                if (is_add_reg && expire) begin
                    head_next  = head_nxt;
                    count_next = count_reg - CNT_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = head_nxt;
                end else begin
                    if (is_add_reg) begin
                        sidx_next = sidx_reg + IDX_W'(1);
                    end
                    cur_next   = sample_reg;
                    min_next   = front_min;
                    err_next   = 1'b0;
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish && !out_free) begin
            state_next = ST_OUT;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_err_next   = m_err_reg;
        if ((finish || state_reg == ST_OUT) && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = min_next;
            m_err_next   = err_next;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign fwd_next = wr_en && rd_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            sidx_reg    <= '0;
            has_reg     <= 1'b0;
            wlen_reg    <= WLEN_W'(1);
            cur_reg     <= '0;
            min_reg     <= '0;
            err_reg     <= 1'b0;
            is_add_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            sidx_reg    <= sidx_next;
            has_reg     <= has_next;
            cur_reg     <= cur_next;
            min_reg     <= min_next;
            err_reg     <= err_next;
            is_add_reg  <= is_add_next;
            m_valid_reg <= m_valid_next;
            fwd_reg     <= fwd_next;
            if (cfg_wr_en) begin
                wlen_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        m_data_reg   <= m_data_next;
        m_err_reg    <= m_err_next;
        fwd_data_reg <= wr_data;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'($unsigned(m_data_reg));
    assign m_tuser  = m_err_reg;

endmodule : sliding_window_minimum
`default_nettype wire

// File: hw/rtl/swm_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// swm_checker
// Port-level checks of the sliding window minimum block.
// ---------------------------------------------------------------------------
module swm_checker
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32,
    localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               cfg_wr_en,
    input wire logic [WLEN_W-1:0]  cfg_wr_data,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic [TDATA_W-1:0] s_tdata,
    input wire logic               s_tuser,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic               m_tuser
);

    logic win_one_reg;
    logic any_add_reg;
    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_one_reg <= 1'b1;
            any_add_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                win_one_reg <= (cfg_wr_data <= WLEN_W'(1));
            end
            if (s_acc && s_tuser == CMD_ADD) begin
                any_add_reg <= 1'b1;
            end
        end
    end

    // A stalled result transaction holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // With a window of one, an add returns its own sample on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser == CMD_ADD && win_one_reg && (!m_tvalid || m_tready)
        |=> m_tvalid && !m_tuser
            && m_tdata[SAMPLE_WIDTH-1:0] == $past(s_tdata[SAMPLE_WIDTH-1:0]))
        else $error("window of one does not pass the sample through");

    // An update before any add is flagged at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser == CMD_UPDATE && !any_add_reg && (!m_tvalid || m_tready)
        |=> m_tvalid && m_tuser)
        else $error("early update not flagged");

endmodule : swm_checker

bind sliding_window_minimum swm_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
);
`default_nettype wire

// File: tb/sv/tb_sliding_window_minimum.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb_sliding_window_minimum
// Self-checking testbench for the sliding window minimum block. A scoreboard
// keeps its own monotonic deque model, predicts the minimum and error flag
// of every accepted command, and compares each result transaction against
// the oldest prediction. Directed corner cases are followed by random phases
// at several window lengths, with random gaps on both streams.
// ---------------------------------------------------------------------------
module tb_sliding_window_minimum;
    import swm_pkg::*;

    localparam int DEPTH       = 256;
    localparam int CYCLE_LIMIT = 500000;
    localparam int NUM_PHASES  = 10;
    localparam logic [WLEN_W-1:0] PHASE_WIN [NUM_PHASES] =
        '{9'd0, 9'd2, 9'd511, 9'd3, 9'd256, 9'd1, 9'd7, 9'd300, 9'd64, 9'd5};

    typedef struct packed {
        logic signed [31:0] window_min;
        logic               error;
    } min_result_t;

    typedef enum int {RUN_RISE, RUN_FALL, RUN_TIES, RUN_WIDE, RUN_EDGE} run_shape_t;

    // Predicts the block from its own copy of the deque and the window length.
    class min_scoreboard;
        logic signed [31:0] dq_val [DEPTH];
        logic [IDX_W-1:0]   dq_idx [DEPTH];
        int                 head, tail, count;
        logic [IDX_W-1:0]   add_count;
        bit                 started;
        logic signed [31:0] cur_sample, cur_min;
        logic [WLEN_W-1:0]  win_len;
        min_result_t        expected_mins [$];
        int                 fail_count;

        function new();
            head = 0;
            tail = 0;
            count = 0;
            add_count = '0;
            started = 0;
            cur_sample = '0;
            cur_min = '0;
            win_len = 9'd1;
            fail_count = 0;
        endfunction

        function void set_window(logic [WLEN_W-1:0] len);
            win_len = len;
        endfunction

        function int pending();
            return expected_mins.size();
        endfunction

        function void drop_front();
            head = (head + 1) % DEPTH;
            count--;
        endfunction

        function void refresh_min();
            if (count == 0 || !(dq_val[head] < cur_sample))
                cur_min = cur_sample;
            else
                cur_min = dq_val[head];
        endfunction

        function min_result_t predict_min(logic cmd, logic signed [31:0] v);
            min_result_t      r;
            int               w;
            int               b;
            logic [IDX_W-1:0] age;
            w = (win_len == 0) ? 1 : (win_len > DEPTH) ? DEPTH : int'(win_len);
            r.error = 1'b0;
            if (cmd == CMD_ADD) begin
                if (!started || w == 1) begin
                    cur_sample = v;
                    cur_min = v;
                    add_count = add_count + IDX_W'(1);
                    started = 1;
                end else begin
                    // Pop back entries not smaller than the value being committed.
                    while (count > 0) begin
                        b = (tail + DEPTH - 1) % DEPTH;
                        if (dq_val[b] < cur_sample)
                            break;
                        tail = b;
                        count--;
                    end
                    if (count >= DEPTH)
                        drop_front();
                    dq_val[tail] = cur_sample;
                    dq_idx[tail] = add_count;
                    tail = (tail + 1) % DEPTH;
                    count++;
                    // Expire front entries; the index distance wraps at 9 bits.
                    while (count > 0) begin
                        age = add_count - dq_idx[head];
                        if (int'(age) + 1 < w)
                            break;
                        drop_front();
                    end
                    add_count = add_count + IDX_W'(1);
                    cur_sample = v;
                    refresh_min();
                end
            end else if (!started) begin
                r.error = 1'b1;
            end else begin
                cur_sample = v;
                refresh_min();
            end
            r.window_min = cur_min;
            return r;
        endfunction

        function void note_command(logic cmd, logic signed [31:0] v);
            min_result_t r;
            r = predict_min(cmd, v);
            expected_mins.insert(expected_mins.size(), r);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            fail_count++;
        endtask

        task check_result(logic signed [31:0] got_min, logic got_err);
            min_result_t exp_r;
            if (expected_mins.size() == 0) begin
                report($sformatf("unexpected result min=%0d error=%0b", got_min, got_err));
            end else begin
                exp_r = expected_mins[0];
                expected_mins.delete(0);
                if (got_min !== exp_r.window_min)
                    report($sformatf("window_min got %0d, expected %0d",
                                     got_min, exp_r.window_min));
                if (got_err !== exp_r.error)
                    report($sformatf("error got %0b, expected %0b", got_err, exp_r.error));
            end
        endtask
    endclass

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [WLEN_W-1:0]  cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata     = '0;    // sample_value
    logic               s_tuser     = 1'b0;  // cmd
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [31:0]        m_tdata;             // window_min
    logic               m_tuser;             // error

    min_scoreboard      sb = new();
    bit                 tx_steady = 0;
    bit                 rx_steady = 0;
    int unsigned        rx_hold   = 0;
    int                 cycle_count = 0;
    run_shape_t         run_shape = RUN_WIDE;
    int                 run_left  = 0;
    logic signed [31:0] run_value = '0;

    sliding_window_minimum dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** sliding_window_minimum: FAILED **");
            $finish;
        end
    end

    // Every accepted command transaction feeds the predictor.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_command(s_tuser, s_tdata);
    end

    // Result side: check each transaction, then stall for a random hold unless rx_steady is set.
    always @(posedge aclk) begin : result_side
        int unsigned hold;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser);
                hold = rx_steady ? 0 : $urandom_range(0, 9);
            end else begin
                hold = (rx_hold != 0) ? rx_hold - 1 : 0;
            end
            rx_hold <= hold;
            m_tready <= (hold == 0);
        end
    end

    task automatic send_item(input logic cmd, input logic signed [31:0] value);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= value;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (sb.pending() != 0);
    endtask

    task automatic write_window(input logic [WLEN_W-1:0] len);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_window(len);
    endtask

    // Samples come in runs of one shape: rising runs grow the deque, falling
    // runs empty it from the back, and narrow ranges produce ties.
    function automatic logic signed [31:0] next_sample();
        logic signed [31:0] edge_vals [5];
        edge_vals = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1};
        if (run_left == 0) begin
            run_shape = run_shape_t'($urandom_range(0, 4));
            run_left = $urandom_range(4, 40);
            run_value = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        end
        run_left--;
        case (run_shape)
            RUN_RISE: run_value = run_value + $signed($urandom_range(1, 1000));
            RUN_FALL: run_value = run_value - $signed($urandom_range(1, 1000));
            RUN_TIES: run_value = $signed($urandom_range(0, 8)) - 4;
            RUN_WIDE: run_value = $urandom();
            default:  run_value = edge_vals[$urandom_range(0, 4)];
        endcase
        return run_value;
    endfunction

    initial begin
        logic               cmd;
        int                 n_items;
        logic               first_cmd [5];
        logic signed [31:0] first_val [5];
        logic               win3_cmd  [14];
        logic signed [31:0] win3_val  [14];

        // Early updates raise the error flag; then the first add and window one.
        first_cmd = '{CMD_UPDATE, CMD_UPDATE, CMD_ADD, CMD_ADD, CMD_UPDATE};
        first_val = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh7fff_ffff, -32'sd1};
        // Window of three: extremes, equal values, expiry and updates.
        win3_cmd = '{CMD_ADD, CMD_ADD, CMD_ADD, CMD_ADD, CMD_UPDATE, CMD_ADD, CMD_ADD,
                     CMD_ADD, CMD_ADD, CMD_UPDATE, CMD_ADD, CMD_ADD, CMD_UPDATE,
                     CMD_ADD};
        win3_val = '{32'sh7fff_ffff, 32'sd0, 32'sh8000_0000, 32'sh8000_0000, 32'sd5,
                     32'sd1, 32'sd2, 32'sd3, 32'sd3, 32'sh7fff_ffff, -32'sd5, -32'sd6,
                     -32'sd7, 32'sd0};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 5; i++)
            send_item(first_cmd[i], first_val[i]);
        write_window(9'd3);
        for (int i = 0; i < 14; i++)
            send_item(win3_cmd[i], win3_val[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_window(PHASE_WIN[p]);
            tx_steady = (p == 2) || ($urandom_range(0, 3) == 0);
            rx_steady = (p == 2) || ($urandom_range(0, 3) == 0);
            n_items = 70;
            run_left = 0;
            if (PHASE_WIN[p] == 9'd256) begin
                // A long rising run grows the deque toward the full window.
                n_items = 330;
                run_shape = RUN_RISE;
                run_left = 280;
                run_value = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            end
            for (int i = 0; i < n_items; i++) begin
                if ((p == 0 && i == 20) || $urandom_range(0, 60) == 0)
                    wait_drained();
                cmd = ($urandom_range(0, 3) == 0) ? CMD_UPDATE : CMD_ADD;
                send_item(cmd, next_sample());
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        if (sb.fail_count == 0) begin
            $display("** sliding_window_minimum: PASSED **");
        end else begin
            $display("** sliding_window_minimum: FAILED **");
        end
        $finish;
    end

endmodule : tb_sliding_window_minimum
`default_nettype wire
